### src/atilt_pkg.sv
package atilt_pkg;

	// CORDIC iteration count; the table below covers at most TABLE_LEN steps
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN    = 24;
	localparam int N_ITER       = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;

	localparam int FRAC_BITS = 16;
	localparam int MAG_W     = 8;
	// magnitude 128 << 16 times CORDIC gain and sqrt(2) stays below 2^25
	localparam int CW        = MAG_W + FRAC_BITS + 3;
	// degrees Q16, holds -270 .. +180
	localparam int ANG_W     = 26;
	localparam int DEG_W     = 10;
	localparam int OUT_W     = 9;

	typedef logic signed [CW-1:0]    vec_t;
	typedef logic signed [ANG_W-1:0] ang_t;
	typedef logic signed [DEG_W-1:0] deg_t;

	localparam ang_t DEG45  = ANG_W'(45 * (1 << FRAC_BITS));
	localparam ang_t DEG90  = ANG_W'(90 * (1 << FRAC_BITS));
	localparam ang_t DEG180 = ANG_W'(180 * (1 << FRAC_BITS));
	localparam ang_t TRUNC_BIAS = ANG_W'((1 << FRAC_BITS) - 1);

	localparam deg_t LIM_DEG  = DEG_W'(180);
	localparam deg_t WRAP_DEG = DEG_W'(360);

	// per-lane classification of the (h, v) pair
	typedef struct packed {
		logic h_neg;
		logic v_neg;
		logic h_zero;
		logic v_zero;
		logic eq;
	} info_t;

	typedef struct packed {
		vec_t cx;
		vec_t cy;
		ang_t ang;
	} cstate_t;

	// lane 0: h = y (tilt about x), lane 1: h = x (tilt about y); v = z for both
	typedef struct packed {
		logic [7:0]     id;
		info_t [1:0]    info;
		cstate_t [1:0]  cs;
	} item_t;

	// round(atan(2^-i) * 180/pi * 65536)
	function automatic ang_t atan_q16(input int unsigned i);
		ang_t r;
		case (i)
			0:  r = ANG_W'(2949120);
			1:  r = ANG_W'(1740967);
			2:  r = ANG_W'(919879);
			3:  r = ANG_W'(466945);
			4:  r = ANG_W'(234379);
			5:  r = ANG_W'(117304);
			6:  r = ANG_W'(58666);
			7:  r = ANG_W'(29335);
			8:  r = ANG_W'(14668);
			9:  r = ANG_W'(7334);
			10: r = ANG_W'(3667);
			11: r = ANG_W'(1833);
			12: r = ANG_W'(917);
			13: r = ANG_W'(458);
			14: r = ANG_W'(229);
			15: r = ANG_W'(115);
			16: r = ANG_W'(57);
			17: r = ANG_W'(29);
			18: r = ANG_W'(14);
			19: r = ANG_W'(7);
			20: r = ANG_W'(4);
			21: r = ANG_W'(2);
			22: r = ANG_W'(1);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

### src/atilt_front.sv
module atilt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	output logic              in_rdy,
	input  logic [7:0]        sensor_id,
	input  logic [7:0]        accel_x,
	input  logic [7:0]        accel_y,
	input  logic [7:0]        accel_z,
	output logic              out_vld,
	input  logic              out_rdy,
	output atilt_pkg::item_t  out_item
);
	import atilt_pkg::*;

	item_t nxt;
	item_t item_s1;
	logic  vld_s1;
	logic  rdy;

	// offset binary to two's complement: flip the top bit
	logic signed [7:0] xs, ys, zs;
	assign xs = {~accel_x[7], accel_x[6:0]};
	assign ys = {~accel_y[7], accel_y[6:0]};
	assign zs = {~accel_z[7], accel_z[6:0]};

	always_comb begin
		logic signed [7:0] hs;
		logic [MAG_W-1:0]  mag_h;
		logic [MAG_W-1:0]  mag_v;
		nxt    = '0;
		nxt.id = sensor_id;
		mag_v  = zs[7] ? (~zs + 8'd1) : zs;
		for (int l = 0; l < 2; l++) begin
			hs    = (l == 0) ? ys : xs;
			mag_h = hs[7] ? (~hs + 8'd1) : hs;
			nxt.info[l].h_neg  = hs[7];
			nxt.info[l].v_neg  = zs[7];
			nxt.info[l].h_zero = (hs == 8'sd0);
			nxt.info[l].v_zero = (zs == 8'sd0);
			nxt.info[l].eq     = (mag_h == mag_v);
			nxt.cs[l].cx  = CW'({mag_h, {FRAC_BITS{1'b0}}});
			nxt.cs[l].cy  = CW'({mag_v, {FRAC_BITS{1'b0}}});
			nxt.cs[l].ang = '0;
		end
	end

	assign rdy    = !vld_s1 || out_rdy;
	assign in_rdy = rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && in_vld) begin
			item_s1 <= nxt;
		end
	end

	assign out_vld  = vld_s1;
	assign out_item = item_s1;

endmodule

### src/atilt_cordic.sv
module atilt_cordic (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_vld,
	output logic              in_rdy,
	input  atilt_pkg::item_t  in_item,
	output logic              out_vld,
	input  logic              out_rdy,
	output atilt_pkg::item_t  out_item
);
	import atilt_pkg::*;

	// one register stage per vectoring iteration, both lanes side by side
	item_t              item_s2 [N_ITER];
	logic [N_ITER-1:0]  vld_s2;
	item_t              src     [N_ITER];
	logic [N_ITER-1:0]  src_vld;
	logic [N_ITER:0]    rdy;

	always_comb begin
		src[0]     = in_item;
		src_vld[0] = in_vld;
		for (int j = 1; j < N_ITER; j++) begin
			src[j]     = item_s2[j-1];
			src_vld[j] = vld_s2[j-1];
		end
	end

	assign rdy[N_ITER] = out_rdy;

	genvar k;
	for (k = 0; k < N_ITER; k++) begin : g_iter
		item_t nxt;

		always_comb begin
			vec_t dx;
			vec_t dy;
			nxt = src[k];
			for (int l = 0; l < 2; l++) begin
				dx = src[k].cs[l].cy >>> k;
				dy = src[k].cs[l].cx >>> k;
				if (!src[k].cs[l].cy[CW-1] && (src[k].cs[l].cy != '0)) begin
					nxt.cs[l].cx  = src[k].cs[l].cx + dx;
					nxt.cs[l].cy  = src[k].cs[l].cy - dy;
					nxt.cs[l].ang = src[k].cs[l].ang + atan_q16(k);
				end else begin
					nxt.cs[l].cx  = src[k].cs[l].cx - dx;
					nxt.cs[l].cy  = src[k].cs[l].cy + dy;
					nxt.cs[l].ang = src[k].cs[l].ang - atan_q16(k);
				end
			end
		end

		assign rdy[k] = !vld_s2[k] || rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s2[k] <= 1'b0;
			end else if (rdy[k]) begin
				vld_s2[k] <= src_vld[k];
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k] && src_vld[k]) begin
				item_s2[k] <= nxt;
			end
		end
	end

	assign in_rdy   = rdy[0];
	assign out_vld  = vld_s2[N_ITER-1];
	assign out_item = item_s2[N_ITER-1];

endmodule

### src/atilt_back.sv
module atilt_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_vld,
	output logic                    in_rdy,
	input  atilt_pkg::item_t        in_item,
	output logic                    out_vld,
	input  logic                    out_rdy,
	output logic [7:0]              out_id,
	output logic signed [atilt_pkg::OUT_W-1:0] tilt_about_x,
	output logic signed [atilt_pkg::OUT_W-1:0] tilt_about_y,
	output logic                    x_degenerate,
	output logic                    y_degenerate
);
	import atilt_pkg::*;

	logic rdy3, rdy4, rdy5;
	logic vld_s3, vld_s4, vld_s5;

	logic [7:0] id_s3, id_s4, id_s5;
	logic [1:0] dgn_s3, dgn_s4, dgn_s5;
	ang_t       theta_s3 [2];
	deg_t       deg_s4   [2];
	logic signed [OUT_W-1:0] tilt_s5 [2];

	// quadrant mapping; degenerate lanes get +90 so they land on zero
	ang_t theta_nxt [2];
	always_comb begin
		ang_t  phi;
		info_t inf;
		for (int l = 0; l < 2; l++) begin
			inf = in_item.info[l];
			if (inf.eq)
				phi = DEG45;
			else if (in_item.cs[l].ang[ANG_W-1])
				phi = '0;
			else if (in_item.cs[l].ang > DEG90)
				phi = DEG90;
			else
				phi = in_item.cs[l].ang;

			if (inf.h_zero && inf.v_zero)
				theta_nxt[l] = DEG90;
			else if (inf.h_zero)
				theta_nxt[l] = inf.v_neg ? -DEG90 : DEG90;
			else if (inf.v_zero)
				theta_nxt[l] = inf.h_neg ? DEG180 : '0;
			else if (!inf.h_neg)
				theta_nxt[l] = inf.v_neg ? -phi : phi;
			else
				theta_nxt[l] = inf.v_neg ? (phi - DEG180) : (DEG180 - phi);
		end
	end

	// subtract 90 and truncate toward zero
	deg_t deg_nxt [2];
	always_comb begin
		ang_t d;
		ang_t biased;
		for (int l = 0; l < 2; l++) begin
			d       = theta_s3[l] - DEG90;
			biased  = d + (d[ANG_W-1] ? TRUNC_BIAS : ang_t'(0));
			deg_nxt[l] = DEG_W'(biased >>> FRAC_BITS);
		end
	end

	// single wrap into -180 .. 180
	logic signed [OUT_W-1:0] wrap_nxt [2];
	always_comb begin
		deg_t w;
		for (int l = 0; l < 2; l++) begin
			if (deg_s4[l] < -LIM_DEG)
				w = deg_s4[l] + WRAP_DEG;
			else if (deg_s4[l] > LIM_DEG)
				w = deg_s4[l] - WRAP_DEG;
			else
				w = deg_s4[l];
			wrap_nxt[l] = OUT_W'(w);
		end
	end

	assign rdy5   = !vld_s5 || out_rdy;
	assign rdy4   = !vld_s4 || rdy5;
	assign rdy3   = !vld_s3 || rdy4;
	assign in_rdy = rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			if (rdy3) vld_s3 <= in_vld;
			if (rdy4) vld_s4 <= vld_s3;
			if (rdy5) vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && in_vld) begin
			id_s3       <= in_item.id;
			dgn_s3[0]   <= in_item.info[0].h_zero && in_item.info[0].v_zero;
			dgn_s3[1]   <= in_item.info[1].h_zero && in_item.info[1].v_zero;
			theta_s3[0] <= theta_nxt[0];
			theta_s3[1] <= theta_nxt[1];
		end
		if (rdy4 && vld_s3) begin
			id_s4     <= id_s3;
			dgn_s4    <= dgn_s3;
			deg_s4[0] <= deg_nxt[0];
			deg_s4[1] <= deg_nxt[1];
		end
		if (rdy5 && vld_s4) begin
			id_s5      <= id_s4;
			dgn_s5     <= dgn_s4;
			tilt_s5[0] <= wrap_nxt[0];
			tilt_s5[1] <= wrap_nxt[1];
		end
	end

	assign out_vld      = vld_s5;
	assign out_id       = id_s5;
	assign tilt_about_x = tilt_s5[0];
	assign tilt_about_y = tilt_s5[1];
	assign x_degenerate = dgn_s5[0];
	assign y_degenerate = dgn_s5[1];

endmodule

### src/accel_tilt_angles.sv
// Tilt angles from one three-axis accelerometer sample. Each transfer on the
// input carries a node id and three offset-binary 8-bit components (128 is
// zero); each output transfer carries the id, atan2(z,y) - 90 and
// atan2(z,x) - 90 in whole degrees (truncated toward zero, wrapped into
// -180..180) and a degenerate flag per angle, set with the angle forced to 0
// when both of its components are zero. One result per sample, in order.
// Throughput is one transfer per clock while out_stall is low: the
// vectoring CORDIC is fully unrolled, one register stage per iteration,
// and both angles run in parallel lanes. The stages are one input stage,
// one stage per CORDIC iteration, then quadrant mapping, truncation and
// wrap. Each stage holds its own valid bit and loads whenever it is empty
// or the stage after it moves, so bubbles are squeezed out and in_stall
// only rises when every stage is full behind a stalled output.
module accel_tilt_angles (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] sensor_id,
	input  logic [7:0] accel_x,
	input  logic [7:0] accel_y,
	input  logic [7:0] accel_z,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_id,
	output logic signed [atilt_pkg::OUT_W-1:0] tilt_about_x,
	output logic signed [atilt_pkg::OUT_W-1:0] tilt_about_y,
	output logic       x_degenerate,
	output logic       y_degenerate
);
	import atilt_pkg::*;

	logic  in_rdy;
	logic  fr_vld, fr_rdy;
	item_t fr_item;
	logic  cd_vld, cd_rdy;
	item_t cd_item;

	assign in_stall = !in_rdy;

	// centering, magnitudes, special-case flags
	atilt_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (in_valid),
		.in_rdy    (in_rdy),
		.sensor_id (sensor_id),
		.accel_x   (accel_x),
		.accel_y   (accel_y),
		.accel_z   (accel_z),
		.out_vld   (fr_vld),
		.out_rdy   (fr_rdy),
		.out_item  (fr_item)
	);

	// first-quadrant angle, both lanes
	atilt_cordic u_cordic (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (fr_vld),
		.in_rdy   (fr_rdy),
		.in_item  (fr_item),
		.out_vld  (cd_vld),
		.out_rdy  (cd_rdy),
		.out_item (cd_item)
	);

	// full-circle mapping, -90, truncate, wrap; last stage is the output register
	atilt_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_vld       (cd_vld),
		.in_rdy       (cd_rdy),
		.in_item      (cd_item),
		.out_vld      (out_valid),
		.out_rdy      (!out_stall),
		.out_id       (out_id),
		.tilt_about_x (tilt_about_x),
		.tilt_about_y (tilt_about_y),
		.x_degenerate (x_degenerate),
		.y_degenerate (y_degenerate)
	);

	// backpressure only comes from a stalled, occupied output
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a stalled output");

	a_dgn_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (x_degenerate || y_degenerate) |->
			((!x_degenerate || tilt_about_x == '0) && (!y_degenerate || tilt_about_y == '0)))
		else $error("degenerate angle not forced to zero");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tilt_about_x >= -LIM_DEG && tilt_about_x <= LIM_DEG &&
			tilt_about_y >= -LIM_DEG && tilt_about_y <= LIM_DEG))
		else $error("tilt angle outside -180..180");

endmodule

### dv/accel_tilt_angles_tb.sv
`timescale 1ns / 100ps

module accel_tilt_angles_tb;

	import atilt_pkg::*;

	// ------------------------------------------------------------------
	// Run constants
	// ------------------------------------------------------------------
	localparam int     ITEMS_PER_PHASE = 650;
	localparam int     LONG_HOLD       = 80;      // well over the 20-deep pipe
	localparam int     SETTLE_CYCLES   = 40;      // idle wait for stray results at the end
	localparam longint TIMEOUT_NS      = 2_000_000;

	// Angle constants, degrees in Q16
	localparam int     Q_FRAC      = 16;
	localparam longint Q_DEG_45    = 45 * 65536;
	localparam longint Q_DEG_90    = 90 * 65536;
	localparam longint Q_DEG_180   = 180 * 65536;
	localparam int     ARCTAN_LEN  = 24;
	localparam int     TILT_STEPS  = (CORDIC_STEPS < ARCTAN_LEN) ? CORDIC_STEPS : ARCTAN_LEN;

	// round(atan(2^-i) * 180/pi * 2^16)
	longint arctan_q16 [0:ARCTAN_LEN-1] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	typedef struct packed {
		logic [7:0] id;
		logic [7:0] x;
		logic [7:0] y;
		logic [7:0] z;
	} accel_sample_t;

	typedef struct packed {
		logic [7:0]              id;
		logic signed [OUT_W-1:0] about_x;
		logic signed [OUT_W-1:0] about_y;
		logic                    x_degen;
		logic                    y_degen;
	} tilt_result_t;

	// ------------------------------------------------------------------
	// Clock, reset, DUT
	// ------------------------------------------------------------------
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [7:0]        sensor_id = '0;
	logic [7:0]        accel_x = '0;
	logic [7:0]        accel_y = '0;
	logic [7:0]        accel_z = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [7:0]        out_id;
	logic signed [OUT_W-1:0] tilt_about_x;
	logic signed [OUT_W-1:0] tilt_about_y;
	logic              x_degenerate;
	logic              y_degenerate;

	always #10 clk = ~clk;

	accel_tilt_angles u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.sensor_id    (sensor_id),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.accel_z      (accel_z),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.out_id       (out_id),
		.tilt_about_x (tilt_about_x),
		.tilt_about_y (tilt_about_y),
		.x_degenerate (x_degenerate),
		.y_degenerate (y_degenerate)
	);

	// ------------------------------------------------------------------
	// Shared bench state
	// ------------------------------------------------------------------
	accel_sample_t pending_samples [$];   // filled by the sequencer, drained by the driver
	tilt_result_t  expected_tilts [$];    // one entry per accepted input transfer
	accel_sample_t next_sample;
	tilt_result_t  oldest_tilt;

	int unsigned sender_idle_pct = 0;     // percent of offers skipped by the driver
	int unsigned rx_stall_pct    = 0;     // percent of cycles the receiver stalls
	bit          sender_hold     = 1'b0;  // sequencer-requested pause of new offers
	int unsigned hold_requests   = 0;     // long receiver hold-offs requested
	int unsigned error_count     = 0;

	// ------------------------------------------------------------------
	// Tilt predictor
	// ------------------------------------------------------------------

	// Vectoring CORDIC on the first quadrant, a and b strictly positive.
	// >>> on a signed longint floors, as the hardware shifts do.
	function automatic longint first_quadrant_angle(input longint a, input longint b);
		longint cx, cy, ang, dx, dy;
		cx = a <<< Q_FRAC;
		cy = b <<< Q_FRAC;
		ang = 0;
		if (a == b)
			return Q_DEG_45;
		for (int i = 0; i < TILT_STEPS; i++) begin
			dx = cy >>> i;
			dy = cx >>> i;
			if (cy > 0) begin
				cx += dx;
				cy -= dy;
				ang += arctan_q16[i];
			end else begin
				cx -= dx;
				cy += dy;
				ang -= arctan_q16[i];
			end
		end
		if (ang < 0)
			ang = 0;
		if (ang > Q_DEG_90)
			ang = Q_DEG_90;
		return ang;
	endfunction

	// atan2(v, h) - 90 degrees, truncated toward zero, wrapped once.
	function automatic void tilt_angle(input int h, input int v, output int deg,
		output logic degen);
		longint theta, phi, d;
		degen = 1'b0;
		deg = 0;
		if (h == 0 && v == 0) begin
			degen = 1'b1;
			return;
		end
		if (h == 0) begin
			theta = (v > 0) ? Q_DEG_90 : -Q_DEG_90;
		end else if (v == 0) begin
			theta = (h > 0) ? 0 : Q_DEG_180;
		end else begin
			phi = first_quadrant_angle((h < 0) ? -h : h, (v < 0) ? -v : v);
			if (h > 0)
				theta = (v > 0) ? phi : -phi;
			else
				theta = (v > 0) ? Q_DEG_180 - phi : phi - Q_DEG_180;
		end
		d = theta - Q_DEG_90;
		if (d >= 0)
			deg = int'(d >>> Q_FRAC);
		else
			deg = -int'((-d) >>> Q_FRAC);
		if (deg < -180)
			deg += 360;
		else if (deg > 180)
			deg -= 360;
	endfunction

	function automatic tilt_result_t predict_tilts(input accel_sample_t s);
		tilt_result_t r;
		int ax, ay;
		logic xd, yd;
		// about x: horizontal y, vertical z; about y: horizontal x, vertical z
		tilt_angle(int'(s.y) - 128, int'(s.z) - 128, ax, xd);
		tilt_angle(int'(s.x) - 128, int'(s.z) - 128, ay, yd);
		r.id      = s.id;
		r.about_x = OUT_W'(ax);
		r.about_y = OUT_W'(ay);
		r.x_degen = xd;
		r.y_degen = yd;
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	function automatic logic [7:0] corner_byte();
		case ($urandom_range(6))
			0:       return 8'd0;
			1:       return 8'd1;
			2:       return 8'd127;
			3:       return 8'd128;
			4:       return 8'd129;
			5:       return 8'd254;
			default: return 8'd255;
		endcase
	endfunction

	// Half uniform bytes; the rest lands on the cases the CORDIC and the
	// quadrant mapping treat specially: near zero, exact axis, equal
	// magnitudes and field corners.
	function automatic accel_sample_t random_sample();
		accel_sample_t s;
		int unsigned kind, m;
		s.id = 8'($urandom);
		s.x  = 8'($urandom);
		s.y  = 8'($urandom);
		s.z  = 8'($urandom);
		kind = $urandom_range(99);
		m    = $urandom_range(1, 127);
		if (kind >= 50 && kind < 65) begin
			s.x = 8'($urandom_range(120, 136));
			s.y = 8'($urandom_range(120, 136));
			s.z = 8'($urandom_range(120, 136));
		end else if (kind >= 65 && kind < 77) begin
			if ($urandom_range(1)) s.x = 8'd128;
			if ($urandom_range(1)) s.y = 8'd128;
			if ($urandom_range(1)) s.z = 8'd128;
		end else if (kind >= 77 && kind < 88) begin
			s.z = $urandom_range(1) ? 8'(128 + m) : 8'(128 - m);
			s.y = $urandom_range(1) ? 8'(128 + m) : 8'(128 - m);
			s.x = $urandom_range(1) ? 8'(128 + m) : 8'(128 - m);
		end else if (kind >= 88) begin
			s.x = corner_byte();
			s.y = corner_byte();
			s.z = corner_byte();
		end
		return s;
	endfunction

	task automatic add_sample(input logic [7:0] id, input logic [7:0] x,
		input logic [7:0] y, input logic [7:0] z);
		pending_samples.push_back({id, x, y, z});
	endtask

	task automatic add_random(input int n);
		repeat (n) pending_samples.push_back(random_sample());
	endtask

	task automatic wait_offered();
		while (pending_samples.size() != 0 || in_valid)
			@(negedge clk);
	endtask

	// Stop offering and let the pipe empty completely.
	task automatic pause_until_drained();
		sender_hold = 1'b1;
		while (in_valid || expected_tilts.size() != 0)
			@(negedge clk);
		sender_hold = 1'b0;
	endtask

	// ------------------------------------------------------------------
	// Input driver: one payload per transfer, held while stalled
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			sensor_id <= '0;
			accel_x   <= '0;
			accel_y   <= '0;
			accel_z   <= '0;
		end else begin
			// transfer at this edge: predict from the payload on the ports
			if (in_valid && !in_stall)
				expected_tilts.push_back(predict_tilts({sensor_id, accel_x, accel_y, accel_z}));
			if (!in_valid || !in_stall) begin
				if (!sender_hold && pending_samples.size() != 0 &&
					$urandom_range(99) >= sender_idle_pct) begin
					next_sample = pending_samples.pop_front();
					in_valid  <= 1'b1;
					sensor_id <= next_sample.id;
					accel_x   <= next_sample.x;
					accel_y   <= next_sample.y;
					accel_z   <= next_sample.z;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Receiver: random stalls plus long hold-offs counted here
	// ------------------------------------------------------------------
	int unsigned hold_left;
	int unsigned holds_served;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall    <= 1'b0;
			hold_left    = 0;
			holds_served = 0;
		end else if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else if (holds_served != hold_requests) begin
			holds_served++;
			hold_left = LONG_HOLD - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_stall_pct);
		end
	end

	// ------------------------------------------------------------------
	// Monitor: every output transfer against the oldest expectation
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_tilts.size() == 0) begin
				$error("unexpected result transfer: out_id %0d", out_id);
				error_count++;
			end else begin
				oldest_tilt = expected_tilts.pop_front();
				if (out_id !== oldest_tilt.id) begin
					$error("out_id: expected %0d, got %0d", oldest_tilt.id, out_id);
					error_count++;
				end
				if (tilt_about_x !== oldest_tilt.about_x) begin
					$error("tilt_about_x: expected %0d, got %0d",
						oldest_tilt.about_x, tilt_about_x);
					error_count++;
				end
				if (tilt_about_y !== oldest_tilt.about_y) begin
					$error("tilt_about_y: expected %0d, got %0d",
						oldest_tilt.about_y, tilt_about_y);
					error_count++;
				end
				if (x_degenerate !== oldest_tilt.x_degen) begin
					$error("x_degenerate: expected %0d, got %0d",
						oldest_tilt.x_degen, x_degenerate);
					error_count++;
				end
				if (y_degenerate !== oldest_tilt.y_degen) begin
					$error("y_degenerate: expected %0d, got %0d",
						oldest_tilt.y_degen, y_degenerate);
					error_count++;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Sequencer
	// ------------------------------------------------------------------
	initial begin
		// phase one: sender rarely idle, receiver stalls most of the time
		sender_idle_pct = 10;
		rx_stall_pct    = 65;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// directed: both components zero, axis cases, equal magnitudes,
		// third quadrant (incl. the wrap past -180), field extremes
		add_sample(8'h00, 8'd128, 8'd128, 8'd128);
		add_sample(8'hff, 8'd128, 8'd128, 8'd200);
		add_sample(8'h01, 8'd128, 8'd128, 8'd0);
		add_sample(8'h02, 8'd255, 8'd255, 8'd128);
		add_sample(8'h03, 8'd0,   8'd0,   8'd128);
		add_sample(8'h04, 8'd200, 8'd200, 8'd200);
		add_sample(8'h05, 8'd56,  8'd56,  8'd200);
		add_sample(8'h06, 8'd56,  8'd56,  8'd56);
		add_sample(8'h07, 8'd200, 8'd200, 8'd56);
		add_sample(8'h08, 8'd10,  8'd40,  8'd20);
		add_sample(8'h09, 8'd0,   8'd0,   8'd0);
		add_sample(8'haa, 8'd255, 8'd0,   8'd255);
		add_sample(8'h55, 8'd0,   8'd255, 8'd0);
		add_sample(8'h80, 8'd255, 8'd255, 8'd255);
		add_sample(8'h7f, 8'd0,   8'd0,   8'd255);
		add_sample(8'h10, 8'd1,   8'd254, 8'd129);
		add_sample(8'h11, 8'd127, 8'd129, 8'd127);
		add_sample(8'h12, 8'd129, 8'd127, 8'd1);
		add_sample(8'h20, 8'd128, 8'd200, 8'd128);
		add_sample(8'h21, 8'd60,  8'd128, 8'd128);
		add_sample(8'h22, 8'd129, 8'd127, 8'd255);
		add_sample(8'h23, 8'd200, 8'd100, 8'd129);
		add_sample(8'h24, 8'd0,   8'd255, 8'd127);
		wait_offered();
		pause_until_drained();

		// random, with a long receiver hold-off right away so the pipe fills
		// and in_stall rises, and a full sender pause midway
		add_random(ITEMS_PER_PHASE);
		hold_requests++;
		while (pending_samples.size() > ITEMS_PER_PHASE / 2)
			@(negedge clk);
		pause_until_drained();
		wait_offered();
		pause_until_drained();

		// phase two: the other way round
		sender_idle_pct = 65;
		rx_stall_pct    = 10;
		add_random(ITEMS_PER_PHASE);
		wait_offered();
		pause_until_drained();

		// phase three: back-to-back, one more long hold-off
		sender_idle_pct = 0;
		rx_stall_pct    = 0;
		add_random(ITEMS_PER_PHASE);
		repeat (50) @(negedge clk);
		hold_requests++;
		wait_offered();
		pause_until_drained();

		// stray results would show up here as unexpected transfers
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// Watchdog: ~10x the slowest expected run
	initial begin
		#(TIMEOUT_NS);
		$display("*** FAILED ***");
		$finish;
	end

endmodule
